>>> design/swdf_pkg.sv
`default_nettype none

package swdf_pkg;

	// Width of the sequence number field on the packet channel.
	localparam int SEQ_FIELD_W = 16;

	// Bitmap geometry: one memory word covers one window of sequence numbers.
	localparam int WORD_BITS = 32;
	localparam int WORD_LOG  = 5;
	localparam int WIN_COUNT = 2048;
	localparam int WIN_W     = 11;

	typedef logic [SEQ_FIELD_W-1:0] seq_field_t;
	typedef logic [WORD_BITS-1:0]   word_t;
	typedef logic [WIN_W-1:0]       win_t;
	typedef logic [WORD_LOG-1:0]    bit_idx_t;
	typedef logic [1:0]             verdict_t;

	localparam verdict_t VERDICT_OK        = 2'd0;
	localparam verdict_t VERDICT_OUTSIDE   = 2'd1;
	localparam verdict_t VERDICT_DUPLICATE = 2'd2;
	localparam verdict_t VERDICT_NOT_NEWER = 2'd3;

	// Window counter distance beyond which a packet is too far ahead.
	localparam win_t AHEAD_LIMIT = win_t'(WIN_COUNT / 2);

	localparam logic MODE_SEQUENTIAL = 1'b0;
	localparam logic MODE_WINDOW     = 1'b1;

	// Decision of the judge stage for the packet in flight.
	typedef struct packed {
		verdict_t verdict;
		logic     mem_we;
		word_t    mem_wdata;
		win_t     rx_win;
		logic     adv_newest;
		logic     clr_req;
		win_t     old_win;
	} decision_t;

	// Window of a sequence number, wrapping modulo the window count.
	function automatic win_t win_of(seq_field_t seq);
		win_of = win_t'(seq >> WORD_LOG);
	endfunction

	// Bit position of a sequence number inside its window.
	function automatic bit_idx_t bit_of(seq_field_t seq);
		bit_of = seq[WORD_LOG-1:0];
	endfunction

endpackage

`default_nettype wire

>>> design/swdf_pkt_if.sv
`default_nettype none

interface swdf_pkt_if;
	logic                    valid;
	logic                    ready;
	swdf_pkg::seq_field_t    sequence_number;

	modport source (output valid, output sequence_number, input ready);
	modport sink (input valid, input sequence_number, output ready);
endinterface

`default_nettype wire

>>> design/swdf_res_if.sv
`default_nettype none

interface swdf_res_if;
	logic                  valid;
	logic                  ready;
	logic                  accepted;
	swdf_pkg::verdict_t    verdict;

	modport source (output valid, output accepted, output verdict, input ready);
	modport sink (input valid, input accepted, input verdict, output ready);
endinterface

`default_nettype wire

>>> design/swdf_cfg_if.sv
`default_nettype none

interface swdf_cfg_if;
	logic valid;
	logic ready;
	logic channel_mode;

	modport source (output valid, output channel_mode, input ready);
	modport sink (input valid, input channel_mode, output ready);
endinterface

`default_nettype wire

>>> design/swdf_bitmap_ram.sv
`default_nettype none

// Window bitmap store: one write port, one registered read port.
module swdf_bitmap_ram (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire swdf_pkg::win_t  waddr,
	input  wire swdf_pkg::word_t wdata,
	input  wire logic            re,
	input  wire swdf_pkg::win_t  raddr,
	output swdf_pkg::word_t      rdata
);

	swdf_pkg::word_t mem [swdf_pkg::WIN_COUNT];
	swdf_pkg::word_t rdata_q;

	// A read in the same cycle as a write to that entry returns the old word.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> design/swdf_judge.sv
`default_nettype none

// Verdict logic for one packet, given its window word and the newest sequence.
module swdf_judge #(
	parameter int SEQ_BITS = 16
) (
	input  wire logic                  mode,
	input  wire logic [SEQ_BITS-1:0]   seq,
	input  wire logic [SEQ_BITS-1:0]   newest,
	input  wire swdf_pkg::word_t       word,
	output swdf_pkg::decision_t        dec
);

	swdf_pkg::seq_field_t seq_ext;
	swdf_pkg::seq_field_t newest_ext;
	swdf_pkg::win_t       rx_win;
	swdf_pkg::win_t       old_win;
	swdf_pkg::win_t       ahead;
	swdf_pkg::bit_idx_t   bit_idx;
	swdf_pkg::word_t      bit_mask;
	logic [SEQ_BITS-1:0]  seq_delta;
	logic                 newer;
	logic                 outside;
	logic                 dup;

	assign seq_ext    = swdf_pkg::seq_field_t'(seq);
	assign newest_ext = swdf_pkg::seq_field_t'(newest);
	assign rx_win     = swdf_pkg::win_of(seq_ext);
	assign old_win    = swdf_pkg::win_of(newest_ext);
	assign bit_idx    = swdf_pkg::bit_of(seq_ext);
	assign bit_mask   = swdf_pkg::word_t'(1) << bit_idx;

	// Serial comparison: newer when the wrapped distance is nonzero and below half.
	assign seq_delta = seq - newest;
	assign newer     = (seq_delta != '0) && !seq_delta[SEQ_BITS-1];

	// Window distance wraps modulo the window count.
	assign ahead   = rx_win - old_win;
	assign outside = ahead > swdf_pkg::AHEAD_LIMIT;
	assign dup     = word[bit_idx];

	always_comb begin
		dec            = '0;
		dec.rx_win     = rx_win;
		dec.old_win    = old_win;
		dec.mem_wdata  = word | bit_mask;
		if (mode == swdf_pkg::MODE_WINDOW) begin
			if (outside) begin
				dec.verdict = swdf_pkg::VERDICT_OUTSIDE;
			end else if (dup) begin
				dec.verdict = swdf_pkg::VERDICT_DUPLICATE;
			end else begin
				dec.verdict    = swdf_pkg::VERDICT_OK;
				dec.mem_we     = 1'b1;
				dec.adv_newest = newer;
				dec.clr_req    = newer && (rx_win != old_win);
			end
		end else begin
			if (newer) begin
				dec.verdict    = swdf_pkg::VERDICT_OK;
				dec.adv_newest = 1'b1;
			end else begin
				dec.verdict = swdf_pkg::VERDICT_NOT_NEWER;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/sequence_window_duplicate_filter.sv
// Sliding-window duplicate filter for received packet sequence numbers. Each
// packet transfer yields one result transfer (accepted flag and verdict), in
// order, through the judge stage register and then the result register. The
// block takes one packet per cycle while the result side is ready; a packet
// that moves the newest sequence into another window makes the packet side
// pause, because the bitmap memory has a single write port and the window being
// left is cleared in the cycle after the packet's own bitmap update. After
// reset a clearing pass writes every bitmap word once, which keeps the packet
// side stalled until it is done; configuration writes are taken at any time.
`default_nettype none

module sequence_window_duplicate_filter #(
	parameter int SEQ_BITS = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	swdf_pkt_if.sink     pkt,
	swdf_res_if.source   res,
	swdf_cfg_if.sink     cfg
);

	// Configuration register.
	logic mode_q;

	// Newest accepted sequence.
	logic [SEQ_BITS-1:0] newest_q;

	// Clearing pass after reset.
	swdf_pkg::win_t init_addr_q;
	logic           init_done_q;

	// Deferred clear of the window that was left.
	logic           clr_pend_q;
	swdf_pkg::win_t clr_addr_q;

	// Most recent memory write, for forwarding.
	logic            fwd_v_q;
	swdf_pkg::win_t  fwd_addr_q;
	swdf_pkg::word_t fwd_data_q;

	// Judge stage.
	logic                s1_v_s1;
	logic [SEQ_BITS-1:0] seq_s1;

	// Result register.
	logic               res_v_q;
	logic               res_acc_q;
	swdf_pkg::verdict_t res_verdict_q;

	logic                pkt_xfer;
	logic [SEQ_BITS-1:0] pkt_seq;
	swdf_pkg::win_t      rd_addr;
	swdf_pkg::word_t     rd_data;
	swdf_pkg::word_t     word;
	swdf_pkg::win_t      s1_win;
	swdf_pkg::decision_t dec;
	logic                s1_adv;
	logic                mem_we;
	swdf_pkg::win_t      mem_waddr;
	swdf_pkg::word_t     mem_wdata;

	assign pkt_seq  = pkt.sequence_number[SEQ_BITS-1:0];
	assign pkt_xfer = pkt.valid && pkt.ready;
	assign rd_addr  = swdf_pkg::win_of(swdf_pkg::seq_field_t'(pkt_seq));

	// The judge stage moves on when the result register is free or being emptied.
	assign s1_adv = s1_v_s1 && (!res_v_q || res.ready);

	// A packet that triggers a window clear blocks a transfer in the cycle it leaves the judge stage.
	assign pkt.ready = init_done_q && (!s1_v_s1 || (s1_adv && !dec.clr_req));
	assign cfg.ready = 1'b1;

	swdf_bitmap_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (pkt_xfer),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Forward the latest write when it hits the window being judged.
	assign s1_win = swdf_pkg::win_of(swdf_pkg::seq_field_t'(seq_s1));
	assign word   = (fwd_v_q && (fwd_addr_q == s1_win)) ? fwd_data_q : rd_data;

	swdf_judge #(
		.SEQ_BITS (SEQ_BITS)
	) u_judge (
		.mode   (mode_q),
		.seq    (seq_s1),
		.newest (newest_q),
		.word   (word),
		.dec    (dec)
	);

	// Write port: clearing pass, then deferred window clear, then bitmap update.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = dec.rx_win;
		mem_wdata = dec.mem_wdata;
		if (!init_done_q) begin
			mem_we    = 1'b1;
			mem_waddr = init_addr_q;
			mem_wdata = '0;
		end else if (clr_pend_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (s1_adv && dec.mem_we) begin
			mem_we = 1'b1;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= swdf_pkg::MODE_WINDOW;
		end else if (cfg.valid && cfg.ready) begin
			mode_q <= cfg.channel_mode;
		end
	end

	// Clearing pass over the whole bitmap memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_addr_q <= '0;
			init_done_q <= 1'b0;
		end else if (!init_done_q) begin
			init_addr_q <= init_addr_q + swdf_pkg::win_t'(1);
			if (init_addr_q == swdf_pkg::win_t'(swdf_pkg::WIN_COUNT - 1)) begin
				init_done_q <= 1'b1;
			end
		end
	end

	// Newest sequence and pending window clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q   <= SEQ_BITS'(1);
			clr_pend_q <= 1'b0;
			clr_addr_q <= '0;
		end else begin
			clr_pend_q <= s1_adv && dec.clr_req;
			if (s1_adv && dec.adv_newest) begin
				newest_q <= seq_s1;
			end
			if (s1_adv && dec.clr_req) begin
				clr_addr_q <= dec.old_win;
			end
		end
	end

	// Record of the latest memory write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else if (mem_we) begin
			fwd_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			fwd_addr_q <= mem_waddr;
			fwd_data_q <= mem_wdata;
		end
	end

	// Judge stage valid and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1 <= 1'b0;
		end else if (pkt_xfer) begin
			s1_v_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_xfer) begin
			seq_s1 <= pkt_seq;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (s1_adv) begin
			res_v_q <= 1'b1;
		end else if (res.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_acc_q     <= (dec.verdict == swdf_pkg::VERDICT_OK);
			res_verdict_q <= dec.verdict;
		end
	end

	assign res.valid    = res_v_q;
	assign res.accepted = res_acc_q;
	assign res.verdict  = res_verdict_q;

`ifndef ASSERT_OFF
	// No packet is taken before the bitmap memory has been cleared.
	a_no_xfer_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_xfer |-> init_done_q)
		else $error("packet transfer during clearing pass");

	// A deferred clear never competes with a packet in the judge stage.
	a_clr_stage_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_pend_q |-> !s1_v_s1)
		else $error("window clear overlaps a judged packet");

	// Bitmap updates come only from window-mode packets outside the clearing work.
	a_seq_mode_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && init_done_q && !clr_pend_q) |-> (s1_adv && mode_q))
		else $error("bitmap written outside window mode");

	// The accepted flag agrees with the verdict code.
	a_acc_matches: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.accepted == (res.verdict == swdf_pkg::VERDICT_OK)))
		else $error("accepted flag disagrees with verdict");
`endif

endmodule

`default_nettype wire
